// ----- rtl/gcp_pkg.sv -----
// Shared widths and index tables for the generalized 4D cross product.
// No dependencies; every other file of the block imports this package.
package gcp_pkg;

  // Coordinate width (signed Q1.14 at 16 bits)
  localparam int COORD_WIDTH = 16;
  localparam int NUM_COORDS  = 4;
  localparam int NUM_VECS    = 3;
  // Minors used by the four components: coordinate pairs (1,2), (1,3), (2,3)
  localparam int NUM_PAIRS   = 3;

  localparam int PROD_W  = 2 * COORD_WIDTH;
  localparam int MINOR_W = PROD_W + 1;
  localparam int TERM_W  = COORD_WIDTH + MINOR_W;
  localparam int OUT_W   = 49;
  localparam int ACC_W   = ((TERM_W > OUT_W) ? TERM_W : OUT_W) + 2;

  // Index widths
  localparam int VEC_IW   = $clog2(NUM_VECS);
  localparam int COORD_IW = $clog2(NUM_COORDS);
  localparam int PAIR_IW  = $clog2(NUM_PAIRS);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [MINOR_W-1:0]     minor_t;
  typedef logic signed [TERM_W-1:0]      term_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [OUT_W-1:0]       out_t;

  // Coordinate rows of each pair
  localparam logic [COORD_IW-1:0] PAIR_Q [NUM_PAIRS] = '{2'd1, 2'd1, 2'd2};
  localparam logic [COORD_IW-1:0] PAIR_R [NUM_PAIRS] = '{2'd3 - 2'd1, 2'd3, 2'd3};

  // Minor kind e leaves out vector e; the remaining two vectors
  localparam logic [VEC_IW-1:0] LO_VEC [NUM_VECS] = '{2'd1, 2'd0, 2'd0};
  localparam logic [VEC_IW-1:0] HI_VEC [NUM_VECS] = '{2'd2, 2'd2, 2'd1};

  // Per output component: pivot row and the pair of the remaining rows
  localparam logic [COORD_IW-1:0] PIVOT_ROW [NUM_COORDS] = '{2'd1, 2'd0, 2'd0, 2'd0};
  localparam logic [PAIR_IW-1:0]  PAIR_SEL  [NUM_COORDS] = '{2'd2, 2'd2, 2'd1, 2'd0};

endpackage

// ----- rtl/gcp_if.sv -----
// Valid/ready channel interfaces for input vector triples and output normals.
// Depends on gcp_pkg for the field widths.
interface gcp_in_if import gcp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t a_0, a_1, a_2, a_3;
  coord_t b_0, b_1, b_2, b_3;
  coord_t c_0, c_1, c_2, c_3;

  modport source (output valid, a_0, a_1, a_2, a_3, b_0, b_1, b_2, b_3,
                  c_0, c_1, c_2, c_3, input ready);
  modport sink   (input valid, a_0, a_1, a_2, a_3, b_0, b_1, b_2, b_3,
                  c_0, c_1, c_2, c_3, output ready);
endinterface

interface gcp_out_if import gcp_pkg::*; ();
  logic valid;
  logic ready;
  out_t n_0, n_1, n_2, n_3;

  modport source (output valid, n_0, n_1, n_2, n_3, input ready);
  modport sink   (input valid, n_0, n_1, n_2, n_3, output ready);
endinterface

// ----- rtl/generalized_cross_product_4d.sv -----
// Generalized 4D cross product: normal orthogonal to three 4D vectors.
// The four-stage pipeline (products, 2x2 minors, pivot products, signed sum)
// takes one item per cycle while the output is not stalled; each stage holds
// while it is full and the next one holds.
// Reset (rst_ni low, asynchronous) empties all stages; data is not cleared.
// Depends on gcp_pkg and gcp_if.sv.
module generalized_cross_product_4d import gcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  gcp_in_if.sink   in_i,
  gcp_out_if.source out_o
);

  localparam int NUM_STAGES = 4;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] adv;

  coord_t vec_in [NUM_VECS][NUM_COORDS];

  // Stage 1: coordinates and the two products of every minor
  coord_t vec1_q  [NUM_VECS][NUM_COORDS];
  prod_t  plo1_q  [NUM_PAIRS][NUM_VECS];
  prod_t  phi1_q  [NUM_PAIRS][NUM_VECS];
  // Stage 2: coordinates and minors
  coord_t vec2_q  [NUM_VECS][NUM_COORDS];
  minor_t minor2_q [NUM_PAIRS][NUM_VECS];
  // Stage 3: pivot products per component and minor kind
  term_t  term3_q [NUM_COORDS][NUM_VECS];
  // Stage 4: results
  out_t   res4_q  [NUM_COORDS];

  // Gather input fields
  always_comb begin
    vec_in[0][0] = in_i.a_0; vec_in[0][1] = in_i.a_1;
    vec_in[0][2] = in_i.a_2; vec_in[0][3] = in_i.a_3;
    vec_in[1][0] = in_i.b_0; vec_in[1][1] = in_i.b_1;
    vec_in[1][2] = in_i.b_2; vec_in[1][3] = in_i.b_3;
    vec_in[2][0] = in_i.c_0; vec_in[2][1] = in_i.c_1;
    vec_in[2][2] = in_i.c_2; vec_in[2][3] = in_i.c_3;
  end

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_i.ready = adv[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: the two products of each minor, from its two vectors
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      vec1_q <= vec_in;
      for (int s = 0; s < NUM_PAIRS; s++) begin
        for (int e = 0; e < NUM_VECS; e++) begin
          plo1_q[s][e] <= PROD_W'(vec_in[LO_VEC[e]][PAIR_Q[s]])
                        * PROD_W'(vec_in[HI_VEC[e]][PAIR_R[s]]);
          phi1_q[s][e] <= PROD_W'(vec_in[LO_VEC[e]][PAIR_R[s]])
                        * PROD_W'(vec_in[HI_VEC[e]][PAIR_Q[s]]);
        end
      end
    end
  end

  // Stage 2: 2x2 minors
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      vec2_q <= vec1_q;
      for (int s = 0; s < NUM_PAIRS; s++) begin
        for (int e = 0; e < NUM_VECS; e++) begin
          minor2_q[s][e] <= MINOR_W'(plo1_q[s][e]) - MINOR_W'(phi1_q[s][e]);
        end
      end
    end
  end

  // Stage 3: pivot coordinate times minor
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        for (int e = 0; e < NUM_VECS; e++) begin
          term3_q[i][e] <= TERM_W'(vec2_q[e][PIVOT_ROW[i]])
                         * TERM_W'(minor2_q[PAIR_SEL[i]][e]);
        end
      end
    end
  end

  function automatic out_t comb_sum(term_t t0, term_t t1, term_t t2, logic neg);
    acc_t sum;
    sum = ACC_W'(t0) - ACC_W'(t1) + ACC_W'(t2);
    if (neg) begin
      sum = -sum;
    end
    return sum[OUT_W-1:0];
  endfunction

  // Stage 4: cofactor sum, negate odd components, wrap to output width
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        res4_q[i] <= comb_sum(term3_q[i][0], term3_q[i][1], term3_q[i][2], i[0]);
      end
    end
  end

  // Drive output channel
  assign out_o.valid = valid_q[NUM_STAGES-1];
  assign out_o.n_0   = res4_q[0];
  assign out_o.n_1   = res4_q[1];
  assign out_o.n_2   = res4_q[2];
  assign out_o.n_3   = res4_q[3];

  // An input transfer always lands in the first stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_q[0])
    else $error("input transfer lost at stage 1");

  // Input is ready only if there is room somewhere in the pipeline
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> out_o.ready || !(&valid_q))
    else $error("input ready with full, stalled pipeline");

  // A stalled result stays, and its components 0 and 3 keep their values
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NUM_STAGES-1] && !out_o.ready |=> valid_q[NUM_STAGES-1] && $stable(res4_q[0])
      && $stable(res4_q[3]))
    else $error("stalled result changed");

endmodule
